### rtl/i2c_master_bit_engine_core_defines.svh
// Assertion macros shared by the I2C master bit engine RTL.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted.
`define I2C_MBE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define I2C_MBE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2C_MBE_ASSERT(label, clk, rst_n, prop, msg)
`define I2C_MBE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/i2c_mbe_pkg.sv
// Package: shared types and constants of the I2C master bit engine.
`timescale 1ns / 1ps
`default_nettype none
package i2c_mbe_pkg;

    localparam int unsigned KIND_W      = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned HALF_W      = 16;
    localparam int unsigned BIT_IDX_W   = 3;

    localparam logic [HALF_W-1:0]    HALF_PERIOD_RST = 16'd125;
    localparam logic [BIT_IDX_W-1:0] BIT_IDX_MSB     = 3'd7;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 3'd0,
        KIND_START   = 3'd1,
        KIND_RESTART = 3'd2,
        KIND_STOP    = 3'd3,
        KIND_WRITE   = 3'd4,
        KIND_READ    = 3'd5
    } t_kind;

endpackage
`default_nettype wire

### rtl/i2c_mbe_if.sv
// Interfaces: input and result channels of the I2C master bit engine.
`timescale 1ns / 1ps
`default_nettype none
interface i2c_mbe_in_if;
    logic                                valid;
    logic                                ready;
    logic [i2c_mbe_pkg::KIND_W-1:0]      kind;
    logic [i2c_mbe_pkg::BYTE_W-1:0]      data_byte;
    logic                                send_ack;
    logic                                sda_level;
    logic                                scl_level;

    modport source (output valid, kind, data_byte, send_ack, sda_level, scl_level,
                    input ready);
    modport sink   (input valid, kind, data_byte, send_ack, sda_level, scl_level,
                    output ready);
endinterface

interface i2c_mbe_out_if;
    logic                                valid;
    logic                                ready;
    logic                                scl_pull_low;
    logic                                sda_pull_low;
    logic                                busy_res;
    logic                                done_res;
    logic                                nack;
    logic [i2c_mbe_pkg::BYTE_W-1:0]      read_value;
    logic                                rejected;

    modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, nack,
                    read_value, rejected, input ready);
    modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, nack,
                    read_value, rejected, output ready);
endinterface
`default_nettype wire

### rtl/i2c_master_bit_engine_core.sv
// Top level: I2C master bit sequencer with registered result channel.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_bit_engine_core_defines.svh"

// Open-drain I2C master driven one tick transaction at a time. A tick carries
// the sampled SDA/SCL levels and moves the bit sequencer by at most one phase;
// a command (start, repeated start, stop, write, read) is taken only while idle
// and a command that arrives while busy is flagged as rejected. Every input
// transaction yields exactly one result transaction: the SCL/SDA pull-low
// drives, busy, a done pulse, NACK and the read byte. The block takes one
// transaction per clock unless the result stalls; the result register is
// loaded with the sequencer registers and is seen in the cycle after
// acceptance. Input stays ready while a result waits, if it is taken in that
// same cycle. Half-period register: ticks per delay phase (0 acts as 1); the
// user must write it via i_cfg_wr_en/i_cfg_wr_data while idle; not enforced.
module i2c_master_bit_engine_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [i2c_mbe_pkg::HALF_W-1:0]     i_cfg_wr_data,
    i2c_mbe_in_if.sink                              i_in,
    i2c_mbe_out_if.source                           o_out
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_HOLD, PH_RS_A, PH_RS_B, PH_RS_C, PH_RS_D,
        PH_SP_A, PH_SP_B, PH_SP_C, PH_WR_LOW, PH_WR_HIGH, PH_WA_LOW,
        PH_WA_WAIT, PH_RD_LOW, PH_RD_HIGH, PH_RA_LOW, PH_RA_WAIT, PH_RA_TAIL
    } t_phase;

    t_phase                                 r_phase, n_phase;
    i2c_mbe_pkg::t_kind                     r_operation, n_operation;
    logic [i2c_mbe_pkg::BIT_IDX_W-1:0]      r_bit_index, n_bit_index;
    logic [i2c_mbe_pkg::BYTE_W-1:0]         r_shift_byte, n_shift_byte;
    logic [i2c_mbe_pkg::HALF_W-1:0]         r_delay_count, n_delay_count;
    logic                                   r_scl_driven, n_scl_driven;
    logic                                   r_sda_driven, n_sda_driven;
    logic                                   r_ack_choice, n_ack_choice;
    logic                                   r_nack_flag, n_nack_flag;
    logic [i2c_mbe_pkg::HALF_W-1:0]         r_half_period;

    logic                                   r_out_valid;
    logic                                   r_out_scl, r_out_sda, r_out_busy, r_out_done;
    logic                                   r_out_nack, r_out_rejected;
    logic [i2c_mbe_pkg::BYTE_W-1:0]         r_out_read_value;

    logic                                   n_done, n_rejected, n_nack;
    logic [i2c_mbe_pkg::BYTE_W-1:0]         n_read_value;

    logic                                   w_accept;
    logic                                   w_is_cmd;
    logic                                   w_do_enter;
    t_phase                                 w_enter_ph;
    logic [i2c_mbe_pkg::HALF_W-1:0]         w_limit;
    logic [i2c_mbe_pkg::HALF_W-1:0]         w_cnt_inc;
    logic                                   w_delay_over;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        case (i_in.kind) inside
            i2c_mbe_pkg::KIND_START, i2c_mbe_pkg::KIND_RESTART, i2c_mbe_pkg::KIND_STOP,
            i2c_mbe_pkg::KIND_WRITE, i2c_mbe_pkg::KIND_READ: w_is_cmd = 1'b1;
            default:                                         w_is_cmd = 1'b0;
        endcase
    end

    assign w_limit      = (r_half_period == '0) ? {{(i2c_mbe_pkg::HALF_W-1){1'b0}}, 1'b1}
                                                : r_half_period;
    assign w_cnt_inc    = r_delay_count + {{(i2c_mbe_pkg::HALF_W-1){1'b0}}, 1'b1};
    assign w_delay_over = (w_cnt_inc >= w_limit) || (w_cnt_inc == '0);

    always_comb begin
        n_phase       = r_phase;
        n_operation   = r_operation;
        n_bit_index   = r_bit_index;
        n_shift_byte  = r_shift_byte;
        n_delay_count = r_delay_count;
        n_scl_driven  = r_scl_driven;
        n_sda_driven  = r_sda_driven;
        n_ack_choice  = r_ack_choice;
        n_nack_flag   = r_nack_flag;
        n_done        = 1'b0;
        n_rejected    = 1'b0;
        w_do_enter    = 1'b0;
        w_enter_ph    = PH_IDLE;

        if (w_is_cmd) begin
            if (r_phase != PH_IDLE) begin
                n_rejected = 1'b1;
            end else begin
                n_operation  = i2c_mbe_pkg::t_kind'(i_in.kind);
                n_shift_byte = i_in.data_byte;
                n_bit_index  = i2c_mbe_pkg::BIT_IDX_MSB;
                n_ack_choice = i_in.send_ack;
                n_nack_flag  = 1'b0;
                w_do_enter   = 1'b1;
                unique case (i_in.kind)
                    i2c_mbe_pkg::KIND_START:   w_enter_ph = PH_ST_HOLD;
                    i2c_mbe_pkg::KIND_RESTART: w_enter_ph = PH_RS_A;
                    i2c_mbe_pkg::KIND_STOP:    w_enter_ph = PH_SP_A;
                    i2c_mbe_pkg::KIND_WRITE:   w_enter_ph = PH_WR_LOW;
                    default: begin
                        n_shift_byte = '0;
                        w_enter_ph   = PH_RD_LOW;
                    end
                endcase
            end
        end else if (i_in.kind == i2c_mbe_pkg::KIND_TICK) begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_WA_WAIT: begin
                    if (i_in.scl_level) begin
                        n_nack_flag = i_in.sda_level;
                        n_phase     = PH_IDLE;
                        n_done      = 1'b1;
                    end
                end
                PH_RA_WAIT: begin
                    if (i_in.scl_level) begin
                        w_do_enter = 1'b1;
                        w_enter_ph = PH_RA_TAIL;
                    end
                end
                default: begin
                    n_delay_count = w_cnt_inc;
                    if (w_delay_over) begin
                        w_do_enter = 1'b1;
                        unique case (r_phase)
                            PH_ST_HOLD: w_enter_ph = PH_WR_LOW;
                            PH_RS_A:    w_enter_ph = PH_RS_B;
                            PH_RS_B:    w_enter_ph = PH_RS_C;
                            PH_RS_C:    w_enter_ph = PH_RS_D;
                            PH_RS_D:    w_enter_ph = PH_WR_LOW;
                            PH_SP_A:    w_enter_ph = PH_SP_B;
                            PH_SP_B:    w_enter_ph = PH_SP_C;
                            PH_WR_LOW:  w_enter_ph = PH_WR_HIGH;
                            PH_WR_HIGH: begin
                                if (r_bit_index == '0) begin
                                    w_enter_ph = PH_WA_LOW;
                                end else begin
                                    n_bit_index = r_bit_index - 1'b1;
                                    w_enter_ph  = PH_WR_LOW;
                                end
                            end
                            PH_WA_LOW:  w_enter_ph = PH_WA_WAIT;
                            PH_RD_LOW:  w_enter_ph = PH_RD_HIGH;
                            PH_RD_HIGH: begin
                                n_shift_byte = {r_shift_byte[i2c_mbe_pkg::BYTE_W-2:0],
                                                i_in.sda_level};
                                if (r_bit_index == '0) begin
                                    w_enter_ph = PH_RA_LOW;
                                end else begin
                                    n_bit_index = r_bit_index - 1'b1;
                                    w_enter_ph  = PH_RD_LOW;
                                end
                            end
                            PH_RA_LOW:  w_enter_ph = PH_RA_WAIT;
                            default: begin
                                // stop tail and read tail finish here
                                w_do_enter    = 1'b0;
                                n_phase       = PH_IDLE;
                                n_delay_count = '0;
                                n_done        = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end

        if (w_do_enter) begin
            n_phase       = w_enter_ph;
            n_delay_count = '0;
            unique case (w_enter_ph)
                PH_ST_HOLD: n_sda_driven = 1'b1;
                PH_RS_A:    n_scl_driven = 1'b1;
                PH_RS_B:    n_sda_driven = 1'b0;
                PH_RS_C:    n_scl_driven = 1'b0;
                PH_RS_D:    n_sda_driven = 1'b1;
                PH_SP_A: begin
                    n_scl_driven = 1'b1;
                    n_sda_driven = 1'b1;
                end
                PH_SP_B:    n_scl_driven = 1'b0;
                PH_SP_C:    n_sda_driven = 1'b0;
                PH_WR_LOW: begin
                    n_scl_driven = 1'b1;
                    n_sda_driven = ~n_shift_byte[n_bit_index];
                end
                PH_WR_HIGH: n_scl_driven = 1'b0;
                PH_WA_LOW: begin
                    n_scl_driven = 1'b1;
                    n_sda_driven = 1'b0;
                end
                PH_WA_WAIT: n_scl_driven = 1'b0;
                PH_RD_LOW: begin
                    n_scl_driven = 1'b1;
                    n_sda_driven = 1'b0;
                end
                PH_RD_HIGH: n_scl_driven = 1'b0;
                PH_RA_LOW: begin
                    n_scl_driven = 1'b1;
                    n_sda_driven = n_ack_choice;
                end
                PH_RA_WAIT: n_scl_driven = 1'b0;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_nack       = 1'b0;
        n_read_value = '0;
        if (n_done) begin
            case (n_operation) inside
                i2c_mbe_pkg::KIND_START, i2c_mbe_pkg::KIND_RESTART,
                i2c_mbe_pkg::KIND_WRITE: n_nack       = n_nack_flag;
                i2c_mbe_pkg::KIND_READ:  n_read_value = n_shift_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_operation   <= i2c_mbe_pkg::KIND_TICK;
            r_bit_index   <= '0;
            r_shift_byte  <= '0;
            r_delay_count <= '0;
            r_scl_driven  <= 1'b0;
            r_sda_driven  <= 1'b0;
            r_ack_choice  <= 1'b0;
            r_nack_flag   <= 1'b0;
            r_half_period <= i2c_mbe_pkg::HALF_PERIOD_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_half_period <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_phase       <= n_phase;
                r_operation   <= n_operation;
                r_bit_index   <= n_bit_index;
                r_shift_byte  <= n_shift_byte;
                r_delay_count <= n_delay_count;
                r_scl_driven  <= n_scl_driven;
                r_sda_driven  <= n_sda_driven;
                r_ack_choice  <= n_ack_choice;
                r_nack_flag   <= n_nack_flag;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out_scl        <= n_scl_driven;
            r_out_sda        <= n_sda_driven;
            r_out_busy       <= (n_phase != PH_IDLE);
            r_out_done       <= n_done;
            r_out_nack       <= n_nack;
            r_out_read_value <= n_read_value;
            r_out_rejected   <= n_rejected;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.scl_pull_low = r_out_scl;
    assign o_out.sda_pull_low = r_out_sda;
    assign o_out.busy_res     = r_out_busy;
    assign o_out.done_res     = r_out_done;
    assign o_out.nack         = r_out_nack;
    assign o_out.read_value   = r_out_read_value;
    assign o_out.rejected     = r_out_rejected;

    `I2C_MBE_ASSERT(a_busy_cmd_rejected, i_clk, i_rst_n, w_accept && w_is_cmd && r_phase != PH_IDLE |=> r_out_valid && r_out_rejected, "command while busy not rejected")
    `I2C_MBE_ASSERT(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_out_done |-> !r_out_busy, "done reported while still busy")
    `I2C_MBE_ASSERT(a_nack_needs_done, i_clk, i_rst_n, r_out_valid && (r_out_nack || r_out_read_value != '0) |-> r_out_done, "nack or read byte without done")
    `I2C_MBE_ASSERT(a_reject_not_done, i_clk, i_rst_n, r_out_valid && r_out_rejected |-> !r_out_done, "rejected transaction also reports done")
    `I2C_MBE_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> r_phase == PH_IDLE && !r_out_valid, "reset did not return sequencer to idle")

endmodule
`default_nettype wire

### test/tb.sv
// Testbench for i2c_master_bit_engine_core: random traffic checked by a line-state predictor.
`timescale 1ns / 1ps
module tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 600;
    localparam int GUARD_MAX   = 400000;
    localparam int SDA_RAND    = 2;

    localparam logic [i2c_mbe_pkg::KIND_W-1:0] KIND_RSVD_LO = 3'd6;
    localparam logic [i2c_mbe_pkg::KIND_W-1:0] KIND_RSVD_HI = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START_HOLD,
        ST_RS_SCL_LOW, ST_RS_SDA_REL, ST_RS_SCL_REL, ST_RS_SDA_LOW,
        ST_SP_PULL, ST_SP_SCL_REL, ST_SP_SDA_REL,
        ST_WR_LOW, ST_WR_HIGH, ST_WACK_LOW, ST_WACK_WAIT,
        ST_RD_LOW, ST_RD_HIGH, ST_RACK_LOW, ST_RACK_WAIT, ST_RACK_TAIL
    } t_bit_phase;

    typedef struct packed {
        logic [i2c_mbe_pkg::KIND_W-1:0] kind;
        logic [i2c_mbe_pkg::BYTE_W-1:0] data_byte;
        logic                           send_ack;
        logic                           sda;
        logic                           scl;
    } t_bus_item;

    typedef struct packed {
        logic                           scl_pull_low;
        logic                           sda_pull_low;
        logic                           busy;
        logic                           done;
        logic                           nack;
        logic [i2c_mbe_pkg::BYTE_W-1:0] read_value;
        logic                           rejected;
    } t_line_status;

    typedef struct packed {
        t_bit_phase                        ph;
        logic [i2c_mbe_pkg::KIND_W-1:0]    op;
        logic [i2c_mbe_pkg::BIT_IDX_W-1:0] bit_idx;
        logic [i2c_mbe_pkg::BYTE_W-1:0]    shreg;
        logic [i2c_mbe_pkg::HALF_W-1:0]    dcnt;
        logic [i2c_mbe_pkg::HALF_W-1:0]    half;
        logic                              scl_drv;
        logic                              sda_drv;
        logic                              ack_sel;
        logic                              nack_flg;
    } t_engine_state;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [i2c_mbe_pkg::HALF_W-1:0] cfg_data;

    i2c_mbe_in_if  in_ch ();
    i2c_mbe_out_if out_ch ();

    i2c_master_bit_engine_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_we),
        .i_cfg_wr_data (cfg_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    always #2 clk = ~clk;

    t_bus_item     tick_cmd_q[$];
    t_line_status  line_status_q[$];
    t_engine_state eng_now;
    t_engine_state eng_plan;
    t_bus_item     cur_item;
    t_line_status  step_res;
    t_line_status  want_res;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            fails = 0;
    int            n_gen = 0;
    int            cycles = 0;
    int            hold_cnt;
    logic          hold_req = 1'b0;
    logic          hold_ack;

    function automatic void enter_ph(inout t_engine_state s, input t_bit_phase p);
        s.ph = p;
        s.dcnt = '0;
        case (p)
            ST_START_HOLD: s.sda_drv = 1'b1;
            ST_RS_SCL_LOW: s.scl_drv = 1'b1;
            ST_RS_SDA_REL: s.sda_drv = 1'b0;
            ST_RS_SCL_REL: s.scl_drv = 1'b0;
            ST_RS_SDA_LOW: s.sda_drv = 1'b1;
            ST_SP_PULL: begin
                s.scl_drv = 1'b1;
                s.sda_drv = 1'b1;
            end
            ST_SP_SCL_REL: s.scl_drv = 1'b0;
            ST_SP_SDA_REL: s.sda_drv = 1'b0;
            ST_WR_LOW: begin
                s.scl_drv = 1'b1;
                s.sda_drv = ~s.shreg[s.bit_idx];
            end
            ST_WR_HIGH, ST_WACK_WAIT, ST_RD_HIGH, ST_RACK_WAIT: s.scl_drv = 1'b0;
            ST_WACK_LOW, ST_RD_LOW: begin
                s.scl_drv = 1'b1;
                s.sda_drv = 1'b0;
            end
            ST_RACK_LOW: begin
                s.scl_drv = 1'b1;
                s.sda_drv = s.ack_sel;
            end
            default: ;
        endcase
    endfunction

    function automatic void i2c_engine_step(inout t_engine_state s, input t_bus_item it,
                                            output t_line_status r);
        logic                           fin;
        logic [i2c_mbe_pkg::HALF_W-1:0] lim;
        fin = 1'b0;
        r = '0;
        if (it.kind >= i2c_mbe_pkg::KIND_START && it.kind <= i2c_mbe_pkg::KIND_READ) begin
            if (s.ph != ST_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                s.op = it.kind;
                s.shreg = it.data_byte;
                s.bit_idx = i2c_mbe_pkg::BIT_IDX_MSB;
                s.ack_sel = it.send_ack;
                s.nack_flg = 1'b0;
                case (it.kind)
                    i2c_mbe_pkg::KIND_START:   enter_ph(s, ST_START_HOLD);
                    i2c_mbe_pkg::KIND_RESTART: enter_ph(s, ST_RS_SCL_LOW);
                    i2c_mbe_pkg::KIND_STOP:    enter_ph(s, ST_SP_PULL);
                    i2c_mbe_pkg::KIND_WRITE:   enter_ph(s, ST_WR_LOW);
                    default: begin
                        s.shreg = '0;
                        enter_ph(s, ST_RD_LOW);
                    end
                endcase
            end
        end else if (it.kind == i2c_mbe_pkg::KIND_TICK && s.ph != ST_IDLE) begin
            if (s.ph == ST_WACK_WAIT) begin
                if (it.scl) begin
                    s.nack_flg = it.sda;
                    s.ph = ST_IDLE;
                    fin = 1'b1;
                end
            end else if (s.ph == ST_RACK_WAIT) begin
                if (it.scl) enter_ph(s, ST_RACK_TAIL);
            end else begin
                lim = (s.half == '0) ? 16'd1 : s.half;
                s.dcnt = s.dcnt + 16'd1;
                if (s.dcnt >= lim || s.dcnt == '0) begin
                    case (s.ph)
                        ST_START_HOLD, ST_RS_SDA_LOW: enter_ph(s, ST_WR_LOW);
                        ST_RS_SCL_LOW: enter_ph(s, ST_RS_SDA_REL);
                        ST_RS_SDA_REL: enter_ph(s, ST_RS_SCL_REL);
                        ST_RS_SCL_REL: enter_ph(s, ST_RS_SDA_LOW);
                        ST_SP_PULL:    enter_ph(s, ST_SP_SCL_REL);
                        ST_SP_SCL_REL: enter_ph(s, ST_SP_SDA_REL);
                        ST_WR_LOW:     enter_ph(s, ST_WR_HIGH);
                        ST_WR_HIGH: begin
                            if (s.bit_idx == '0) begin
                                enter_ph(s, ST_WACK_LOW);
                            end else begin
                                s.bit_idx = s.bit_idx - 3'd1;
                                enter_ph(s, ST_WR_LOW);
                            end
                        end
                        ST_WACK_LOW:   enter_ph(s, ST_WACK_WAIT);
                        ST_RD_LOW:     enter_ph(s, ST_RD_HIGH);
                        ST_RD_HIGH: begin
                            s.shreg = {s.shreg[i2c_mbe_pkg::BYTE_W-2:0], it.sda};
                            if (s.bit_idx == '0) begin
                                enter_ph(s, ST_RACK_LOW);
                            end else begin
                                s.bit_idx = s.bit_idx - 3'd1;
                                enter_ph(s, ST_RD_LOW);
                            end
                        end
                        ST_RACK_LOW:   enter_ph(s, ST_RACK_WAIT);
                        default: begin
                            s.ph = ST_IDLE;
                            s.dcnt = '0;
                            fin = 1'b1;
                        end
                    endcase
                end
            end
        end
        r.scl_pull_low = s.scl_drv;
        r.sda_pull_low = s.sda_drv;
        r.busy = (s.ph != ST_IDLE);
        r.done = fin;
        r.nack = fin && (s.op == i2c_mbe_pkg::KIND_START || s.op == i2c_mbe_pkg::KIND_RESTART
                         || s.op == i2c_mbe_pkg::KIND_WRITE) && s.nack_flg;
        r.read_value = (fin && s.op == i2c_mbe_pkg::KIND_READ) ? s.shreg : '0;
    endfunction

    task automatic push(input t_bus_item it);
        t_line_status unused;
        i2c_engine_step(eng_plan, it, unused);
        tick_cmd_q.push_back(it);
        n_gen++;
    endtask

    // one command, then ticks with random stray commands until the operation completes
    task automatic run_op(input logic [i2c_mbe_pkg::KIND_W-1:0] k,
                          input logic [i2c_mbe_pkg::BYTE_W-1:0] d,
                          input logic ack, input int sda_mode, input int noise_pct);
        t_bus_item it;
        int        guard;
        logic      waiting;
        it.kind = k;
        it.data_byte = d;
        it.send_ack = ack;
        it.sda = 1'($urandom);
        it.scl = 1'($urandom);
        push(it);
        guard = 0;
        while (eng_plan.ph != ST_IDLE && guard < GUARD_MAX) begin
            it.data_byte = 8'($urandom);
            it.send_ack = 1'($urandom);
            if ($urandom_range(0, 99) < noise_pct) begin
                it.kind = 3'($urandom_range(i2c_mbe_pkg::KIND_START, KIND_RSVD_HI));
                push(it);
            end
            waiting = (eng_plan.ph == ST_WACK_WAIT || eng_plan.ph == ST_RACK_WAIT);
            it.kind = i2c_mbe_pkg::KIND_TICK;
            it.sda = (sda_mode == SDA_RAND) ? 1'($urandom) : 1'(sda_mode);
            it.scl = waiting ? ($urandom_range(0, 2) != 0) : 1'($urandom);
            push(it);
            guard++;
        end
        if ($urandom_range(0, 9) == 0) begin
            it.kind = ($urandom_range(0, 1) != 0) ? KIND_RSVD_LO : KIND_RSVD_HI;
            push(it);
        end
    endtask

    task automatic gen_traffic(input int target);
        int                             stop_at;
        int                             n;
        logic [i2c_mbe_pkg::KIND_W-1:0] k;
        stop_at = n_gen + target;
        while (n_gen < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                k = 3'($urandom_range(i2c_mbe_pkg::KIND_START, i2c_mbe_pkg::KIND_READ));
                run_op(k, 8'($urandom), 1'($urandom), SDA_RAND, 5);
            end else begin
                run_op(i2c_mbe_pkg::KIND_START, 8'($urandom), 1'($urandom), SDA_RAND, 5);
                n = $urandom_range(0, 3);
                repeat (n) begin
                    k = ($urandom_range(0, 1) != 0) ? i2c_mbe_pkg::KIND_WRITE
                                                     : i2c_mbe_pkg::KIND_READ;
                    run_op(k, 8'($urandom), 1'($urandom), SDA_RAND, 5);
                end
                if ($urandom_range(0, 4) == 0) begin
                    run_op(i2c_mbe_pkg::KIND_RESTART, 8'($urandom), 1'($urandom),
                           SDA_RAND, 5);
                    k = ($urandom_range(0, 1) != 0) ? i2c_mbe_pkg::KIND_WRITE
                                                     : i2c_mbe_pkg::KIND_READ;
                    run_op(k, 8'($urandom), 1'($urandom), SDA_RAND, 5);
                end
                run_op(i2c_mbe_pkg::KIND_STOP, 8'($urandom), 1'($urandom), SDA_RAND, 5);
            end
        end
    endtask

    // sampled away from the rising edge so that pending drives have settled
    task automatic drain();
        while (tick_cmd_q.size() != 0 || in_ch.valid || line_status_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_half(input logic [i2c_mbe_pkg::HALF_W-1:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        eng_now.half = v;
        eng_plan.half = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic cmp(input string fld, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", fld, want, got);
            fails++;
        end
    endtask

    // driver; prediction happens on each accepted transaction
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                i2c_engine_step(eng_now, cur_item, step_res);
                line_status_q.push_back(step_res);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (tick_cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item = tick_cmd_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.kind <= cur_item.kind;
                    in_ch.data_byte <= cur_item.data_byte;
                    in_ch.send_ack <= cur_item.send_ack;
                    in_ch.sda_level <= cur_item.sda;
                    in_ch.scl_level <= cur_item.scl;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            hold_cnt <= 0;
            hold_ack <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req != hold_ack) begin
            hold_cnt <= HOLD_CYCLES;
            hold_ack <= hold_req;
        end
    end

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (line_status_q.size() == 0) begin
                    $error("result transaction with nothing pending");
                    fails++;
                end else begin
                    want_res = line_status_q.pop_front();
                    cmp("scl_pull_low", want_res.scl_pull_low, out_ch.scl_pull_low);
                    cmp("sda_pull_low", want_res.sda_pull_low, out_ch.sda_pull_low);
                    cmp("busy_res", want_res.busy, out_ch.busy_res);
                    cmp("done_res", want_res.done, out_ch.done_res);
                    cmp("nack", want_res.nack, out_ch.nack);
                    cmp("read_value", want_res.read_value, out_ch.read_value);
                    cmp("rejected", want_res.rejected, out_ch.rejected);
                end
            end
            out_ch.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        t_bus_item spare;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = i2c_mbe_pkg::KIND_TICK;
        in_ch.data_byte = '0;
        in_ch.send_ack = 1'b0;
        in_ch.sda_level = 1'b1;
        in_ch.scl_level = 1'b1;
        out_ch.ready = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 45;
        eng_now = '0;
        eng_now.ph = ST_IDLE;
        eng_now.half = i2c_mbe_pkg::HALF_PERIOD_RST;
        eng_plan = eng_now;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset half period
        run_op(i2c_mbe_pkg::KIND_STOP, 8'h00, 1'b0, SDA_RAND, 0);

        // directed: zero half period acts as one tick
        set_half('0);
        run_op(i2c_mbe_pkg::KIND_START, 8'hA5, 1'b0, 0, 0);
        run_op(i2c_mbe_pkg::KIND_WRITE, 8'hFF, 1'b1, 1, 0);
        run_op(i2c_mbe_pkg::KIND_WRITE, 8'h00, 1'b0, 0, 0);
        run_op(i2c_mbe_pkg::KIND_READ, 8'h00, 1'b1, 1, 0);
        run_op(i2c_mbe_pkg::KIND_READ, 8'hFF, 1'b0, 0, 0);
        run_op(i2c_mbe_pkg::KIND_RESTART, 8'h5A, 1'b1, SDA_RAND, 50);
        run_op(i2c_mbe_pkg::KIND_STOP, 8'hC3, 1'b1, SDA_RAND, 0);
        spare = '0;
        spare.kind = KIND_RSVD_LO;
        push(spare);
        spare.kind = KIND_RSVD_HI;
        spare.data_byte = 8'hFF;
        spare.send_ack = 1'b1;
        push(spare);

        set_half(16'd1);
        hold_req <= ~hold_req;
        gen_traffic(200);

        set_half(16'd2);
        send_idle_pct = 45;
        recv_idle_pct = 31;
        gen_traffic(100);
        drain();
        gen_traffic(100);

        set_half('0);
        gen_traffic(150);

        set_half(16'($urandom_range(1, 4)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_traffic(150);

        // longest half period: a stop that stays in its first phase
        set_half(16'hFFFF);
        spare = '0;
        spare.kind = i2c_mbe_pkg::KIND_STOP;
        push(spare);
        spare.kind = i2c_mbe_pkg::KIND_TICK;
        repeat (40) push(spare);

        drain();
        repeat (10) @(posedge clk);
        if (fails == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
